>>> rtl/core/epoch_seconds_to_calendar_unit_defines.svh
// assertion macros shared by the checker of the epoch to calendar unit
// expects i_clk and i_rst_n in the scope of each use
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define ESTC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define ESTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/estc_pkg.sv
// types, constants and helper functions of the epoch to calendar unit
// no dependencies
`default_nettype none

package estc_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam logic [7:0]  YEAR_FIRST    = 8'd70;   // 1970 minus 1900
    localparam logic [7:0]  YEAR_NO_LEAP  = 8'd200;  // 2100, divisible by 100 but not 400
    localparam logic [3:0]  MONTH_FEB     = 4'd1;
    localparam logic [3:0]  MONTH_DEC     = 4'd11;
    localparam logic [15:0] WEEKDAY_SHIFT = 16'd4;   // epoch day was a thursday

    // reciprocals for the constant divisions, exact over each dividend range
    localparam logic [25:0] RECIP_DAY  = 26'd50903317; // ceil(2^35 / 675), 86400 = 675 << 7
    localparam logic [25:0] RECIP_HOUR = 26'd9321;     // ceil(2^21 / 225), 3600 = 225 << 4
    localparam logic [25:0] RECIP_MIN  = 26'd1093;     // ceil(2^14 / 15), 60 = 15 << 2
    localparam logic [25:0] RECIP_WDAY = 26'd74899;    // ceil(2^19 / 7)

    typedef struct packed {
        logic signed [4:0] zone_offset_hours;
    } t_cfg_item;

    typedef struct packed {
        logic [31:0] epoch_seconds;
    } t_in_item;

    typedef struct packed {
        logic [7:0] years_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
        logic [2:0] weekday;
    } t_out_item;

    // constant divisions, in issue order
    typedef enum logic [1:0] {
        DIV_DAY  = 2'd0,
        DIV_HOUR = 2'd1,
        DIV_MIN  = 2'd2,
        DIV_WDAY = 2'd3
    } t_div_op;

    typedef struct packed {
        logic    load_in;
        logic    div_quo;
        logic    div_rem;
        t_div_op div_op;
        logic    year_step;
        logic    month_step;
        logic    capture;
    } t_dp_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_status;

    function automatic logic [16:0] estc_divisor(input t_div_op op);
        logic [16:0] d;
        case (op)
            DIV_DAY:  d = 17'(SECS_PER_DAY);
            DIV_HOUR: d = 17'(SECS_PER_HOUR);
            DIV_MIN:  d = 17'(SECS_PER_MIN);
            default:  d = 17'(DAYS_PER_WEEK);
        endcase
        return d;
    endfunction

    // years 1970..2106 only: divisible by four, except 2100
    function automatic logic estc_is_leap(input logic [7:0] yrs);
        return (yrs[1:0] == 2'b00) && (yrs != YEAR_NO_LEAP);
    endfunction

    function automatic logic [4:0] estc_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:                    len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/estc_chan_if.sv
// valid/ready channel carrying one payload of a given type
// used by the epoch to calendar unit for config, input and output
`default_nettype none

interface estc_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/epoch_seconds_to_calendar_unit.sv
// time from request to result grows with Y, the whole years walked (0..136), and M,
// the whole months walked (0..11)
// throughput: one request at a time, the next taken the cycle after the result is stored
// the year walk, one year per cycle, dominates; the four divisions come before it
// reset (synchronous, active low) puts the controller in idle and clears the output valid
// and the zone offset to zero; result payload registers are not reset
`default_nettype none

module epoch_seconds_to_calendar_unit
    import estc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    estc_chan_if.sink     i_cfg,    // zone offset writes, always accepted
    estc_chan_if.sink     i_in,     // epoch second requests
    estc_chan_if.source   o_out     // broken-down calendar results
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_cfg_item  w_cfg;
    t_in_item   w_in;
    t_out_item  w_result;
    logic       w_in_ready;
    logic       w_out_valid;

    // the offset register can take a write in any cycle
    assign i_cfg.ready = 1'b1;
    assign w_cfg       = i_cfg.payload;
    assign w_in        = i_in.payload;

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = w_out_valid;
    assign o_out.payload = w_result;

    // controller: idle, then for each of day, hour, minute and weekday a
    // quotient state and a remainder state, then the year walk, the month
    // walk, and a wait until the output register is free
    estc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: offset add at request, quotient by reciprocal multiply and
    // remainder by multiply and subtract, one year or month subtracted per
    // cycle, output register
    estc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_zone      (w_cfg.zone_offset_hours),
        .i_epoch_seconds (w_in.epoch_seconds),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_result        (w_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/estc_datapath.sv
// datapath: offset add, reciprocal constant divisions, year and month walk
// depends on estc_pkg
`default_nettype none

module estc_datapath
    import estc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic signed [4:0] i_cfg_zone,
    input  wire logic [31:0]       i_epoch_seconds,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    output t_out_item              o_result
);

    logic signed [4:0] r_zone;
    logic [31:0]       r_secs;
    logic [15:0]       r_days;
    logic [16:0]       r_sod;
    logic [11:0]       r_soh;
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [5:0]        r_sec;
    logic [2:0]        r_wday;
    logic [7:0]        r_year;
    logic [3:0]        r_month;
    logic [15:0]       r_dleft;
    logic [15:0]       r_quo;
    t_out_item         r_out;

    logic signed [16:0] w_off;
    logic [31:0]        w_secs;
    logic [24:0]        w_mul_x;
    logic [25:0]        w_mul_m;
    logic [50:0]        w_mul_p;
    logic [15:0]        w_quo;
    logic [31:0]        w_dvd;
    logic [16:0]        w_div;
    logic [32:0]        w_rem_p;
    logic [31:0]        w_rem;
    logic [15:0]        w_wsum;
    logic               w_leap;
    logic [8:0]         w_ylen;
    logic [4:0]         w_mlen;
    logic               w_year_done;
    logic               w_month_done;

    // offset in seconds fits 17 signed bits, then wraps into the 32-bit count
    assign w_off  = $signed({{12{r_zone[4]}}, r_zone}) * $signed(17'(SECS_PER_HOUR));
    assign w_secs = i_epoch_seconds + {{15{w_off[16]}}, w_off};

    assign w_wsum = r_days + WEEKDAY_SHIFT;

    // quotient: dividend pre-shifted by the divisor's power of two, times reciprocal
    always_comb begin
        case (i_cmd.div_op)
            DIV_DAY: begin
                w_mul_x = r_secs[31:7];
                w_mul_m = RECIP_DAY;
                w_dvd   = r_secs;
            end
            DIV_HOUR: begin
                w_mul_x = {12'd0, r_sod[16:4]};
                w_mul_m = RECIP_HOUR;
                w_dvd   = {15'd0, r_sod};
            end
            DIV_MIN: begin
                w_mul_x = {15'd0, r_soh[11:2]};
                w_mul_m = RECIP_MIN;
                w_dvd   = {20'd0, r_soh};
            end
            default: begin
                w_mul_x = {9'd0, w_wsum};
                w_mul_m = RECIP_WDAY;
                w_dvd   = {16'd0, w_wsum};
            end
        endcase
    end

    assign w_mul_p = 51'(w_mul_x) * 51'(w_mul_m);

    always_comb begin
        case (i_cmd.div_op)
            DIV_DAY:  w_quo = w_mul_p[50:35];
            DIV_HOUR: w_quo = {11'd0, w_mul_p[25:21]};
            DIV_MIN:  w_quo = {10'd0, w_mul_p[19:14]};
            default:  w_quo = {3'd0, w_mul_p[31:19]};
        endcase
    end

    // remainder from the registered quotient
    assign w_div   = estc_divisor(i_cmd.div_op);
    assign w_rem_p = 33'(r_quo) * 33'(w_div);
    assign w_rem   = w_dvd - w_rem_p[31:0];

    assign w_leap       = estc_is_leap(r_year);
    assign w_ylen       = w_leap ? 9'd366 : 9'd365;
    assign w_mlen       = estc_month_len(r_month, w_leap);
    assign w_year_done  = (r_dleft < {7'd0, w_ylen});
    assign w_month_done = (r_dleft < {11'd0, w_mlen}) || (r_month == MONTH_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_zone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_secs <= w_secs;
        end
        if (i_cmd.div_quo) begin
            r_quo <= w_quo;
        end
        if (i_cmd.div_rem) begin
            case (i_cmd.div_op)
                DIV_DAY: begin
                    r_days  <= r_quo;
                    r_sod   <= w_rem[16:0];
                    r_dleft <= r_quo;
                    r_year  <= YEAR_FIRST;
                    r_month <= '0;
                end
                DIV_HOUR: begin
                    r_hour <= r_quo[4:0];
                    r_soh  <= w_rem[11:0];
                end
                DIV_MIN: begin
                    r_min <= r_quo[5:0];
                    r_sec <= w_rem[5:0];
                end
                default: begin
                    r_wday <= w_rem[2:0];
                end
            endcase
        end
        if (i_cmd.year_step && !w_year_done) begin
            r_dleft <= r_dleft - {7'd0, w_ylen};
            r_year  <= r_year + 8'd1;
        end
        if (i_cmd.month_step && !w_month_done) begin
            r_dleft <= r_dleft - {11'd0, w_mlen};
            r_month <= r_month + 4'd1;
        end
        if (i_cmd.capture) begin
            r_out.years_since_1900 <= r_year;
            r_out.month_index      <= r_month;
            r_out.day_of_month     <= r_dleft[4:0] + 5'd1;
            r_out.hour_of_day      <= r_hour;
            r_out.minute_of_hour   <= r_min;
            r_out.second_of_minute <= r_sec;
            r_out.weekday          <= r_wday;
        end
    end

    assign o_status.year_done  = w_year_done;
    assign o_status.month_done = w_month_done;
    assign o_result            = r_out;

endmodule

`default_nettype wire

>>> rtl/core/estc_ctrl.sv
// controller: sequences the divisions, the year and month walk and the handshakes
// depends on estc_pkg
`default_nettype none

module estc_ctrl
    import estc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_QUO   = 6'b000010,
        S_REM   = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    t_div_op    r_op, n_op;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_capture;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_capture  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = DIV_DAY;
                    n_state = S_QUO;
                end
            end
            S_QUO: begin
                n_state = S_REM;
            end
            S_REM: begin
                unique case (r_op)
                    DIV_DAY:  n_op = DIV_HOUR;
                    DIV_HOUR: n_op = DIV_MIN;
                    DIV_MIN:  n_op = DIV_WDAY;
                    default:  n_op = DIV_DAY;
                endcase
                n_state = (r_op == DIV_WDAY) ? S_YEAR : S_QUO;
            end
            S_YEAR: begin
                if (i_status.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_capture) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= DIV_DAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.load_in    = w_accept;
    assign o_cmd.div_quo    = (r_state == S_QUO);
    assign o_cmd.div_rem    = (r_state == S_REM);
    assign o_cmd.div_op     = r_op;
    assign o_cmd.year_step  = (r_state == S_YEAR);
    assign o_cmd.month_step = (r_state == S_MONTH);
    assign o_cmd.capture    = w_capture;
    assign o_out_valid      = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/core/estc_checker.sv
// port-level checker of the epoch to calendar unit, bound to the top level
// depends on estc_pkg and epoch_seconds_to_calendar_unit_defines.svh
`default_nettype none

`include "epoch_seconds_to_calendar_unit_defines.svh"

module estc_checker
    import estc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_payload
);

    // a stalled result keeps its value
    `ESTC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "result changed while stalled")

    // one request in flight: no second request right after one is taken
    `ESTC_ASSERT_NEXT(a_one_request, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")

    `ESTC_ASSERT_IMPL(a_time_range, i_out_valid, (i_out_payload.hour_of_day <= 5'd23) && (i_out_payload.minute_of_hour <= 6'd59) && (i_out_payload.second_of_minute <= 6'd59), "time of day out of range")

    `ESTC_ASSERT_IMPL(a_date_range, i_out_valid, (i_out_payload.years_since_1900 >= 8'd70) && (i_out_payload.years_since_1900 <= 8'd206) && (i_out_payload.month_index <= 4'd11) && (i_out_payload.day_of_month != 5'd0) && (i_out_payload.weekday <= 3'd6), "date out of range")

endmodule

bind epoch_seconds_to_calendar_unit estc_checker u_estc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire
